// ----- hw/rtl/stream_reassembly_range_tracker_assert.svh -----
// ----------------------------------------------------------------------------
// Range tracker assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STREAM_REASSEMBLY_RANGE_TRACKER_ASSERT_SVH
`define STREAM_REASSEMBLY_RANGE_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SRRT_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define SRRT_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define SRRT_ASSERT_IMP(label, clk, rst_n, a, c)
`define SRRT_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- hw/rtl/srrt_pkg.sv -----
// ----------------------------------------------------------------------------
// Range tracker package
// Shared types, status codes and sizes of the stream range tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package srrt_pkg;
	localparam int SRRT_MAX_RANGES = 16;
	localparam int OFF_W = 62;

	// one stored byte range [start_off, end_off)
	typedef struct packed {
		logic [OFF_W-1:0] start_off;
		logic [OFF_W-1:0] end_off;
		logic             eof;
	} rng_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_EOF = 3'd1,
		ST_EOF_MID = 3'd2,
		ST_AFTER   = 3'd3,
		ST_WINDOW  = 3'd4,
		ST_FULL    = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SEG_END, S_SEG_CHK, S_SEG_TRIM,
		S_RD_CHK, S_RD_AVAIL, S_RD_TAKE, S_RD_UPD, S_RD_EOF,
		S_SW_START, S_SW_RUN, S_SW_TAIL, S_DONE
	} fsm_t;
endpackage
`default_nettype wire

// ----- hw/rtl/srrt_table.sv -----
// ----------------------------------------------------------------------------
// Range table memory
// Two banks of range entries; a sweep reads one bank and rewrites the other.
// ----------------------------------------------------------------------------
`default_nettype none
module srrt_table
	import srrt_pkg::*;
#(
	parameter int MAX_RANGES = SRRT_MAX_RANGES,
	localparam int IW = $clog2(MAX_RANGES)
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic          rd_bank,
	input  wire logic [IW-1:0] rd_idx,
	output rng_t               rd_data,
	input  wire logic          wr_en,
	input  wire logic          wr_bank,
	input  wire logic [IW-1:0] wr_idx,
	input  rng_t               wr_data
);
	rng_t mem_q [2**(IW+1)];
	rng_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[{wr_bank, wr_idx}] <= wr_data;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[{rd_bank, rd_idx}];
		end
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

// ----- hw/rtl/stream_reassembly_range_tracker.sv -----
// One item is taken at a time; a segment, or a read that finds data, may run a
// table sweep that streams the stored ranges through the merge step.
// A result waits in the output register while the next item may be taken.
// Reset (arst_n low, async) empties the table and clears all tracking state.
`default_nettype none
`include "stream_reassembly_range_tracker_assert.svh"
// ----------------------------------------------------------------------------
// Stream reassembly range tracker
// Sorted table of received byte ranges with final-size checks and reads.
// ----------------------------------------------------------------------------
module stream_reassembly_range_tracker
	import srrt_pkg::*;
#(
	parameter int MAX_RANGES = SRRT_MAX_RANGES
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [31:0]  cfg_wr_data,   // window_limit
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [111:0] s_tdata,       // seg_offset, seg_length, read_amount
	input  wire logic         s_tlast,       // seg_eof
	input  wire logic         s_tuser,       // action
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [191:0]      m_tdata,       // out_offset, out_length, highest_offset
	output logic              m_tlast,       // out_eof
	output logic [2:0]        m_tuser        // status
);
	localparam int IW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_RANGES);

	fsm_t state_q, state_d;

	logic [31:0]      wl_q, amt_q;
	logic             act_q, eofin_q;
	logic [OFF_W-1:0] off_q, end_q, rp_q, fs_q, ms_q;
	logic [15:0]      len_q;
	logic             fk_q;
	logic [OFF_W-1:0] s_q, e_q;
	logic             f_q, pend_q, merged_q;
	logic             hit_q, drop_q;
	logic [OFF_W-1:0] avail_q, take_q;
	logic [CW-1:0]    k_q, w_q, count_q;
	logic             bank_q;
	status_t          st_q;
	logic [OFF_W-1:0] ooff_q, olen_q;
	logic             oeof_q;
	logic             m_valid_q;
	logic [191:0]     m_data_q;
	logic             m_last_q;
	logic [2:0]       m_user_q;

	logic          tbl_ren, tbl_wen;
	logic [IW-1:0] tbl_ridx;
	rng_t          tbl_rdata, tbl_wdata;

	// sweep decisions
	logic do_adv, do_merge, do_emit, full_hit, last_k, out_load;
	logic [CW-1:0] k_nx;
	logic [62:0] sum;

	assign sum = {1'b0, off_q} + {47'b0, len_q};
	assign last_k = (k_q == count_q - CW'(1));
	assign k_nx = k_q + CW'(1);
	assign full_hit = (count_q == MAXC) && !merged_q;
	assign out_load = !m_valid_q || m_tready;

	srrt_table #(.MAX_RANGES(MAX_RANGES)) u_table (
		.clk(clk), .rd_en(tbl_ren), .rd_bank(bank_q), .rd_idx(tbl_ridx),
		.rd_data(tbl_rdata), .wr_en(tbl_wen), .wr_bank(!bank_q),
		.wr_idx(w_q[IW-1:0]), .wr_data(tbl_wdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and table control
	always_comb begin
		state_d   = state_q;
		tbl_ren   = 1'b0;
		tbl_ridx  = '0;
		tbl_wen   = 1'b0;
		tbl_wdata = tbl_rdata;
		do_adv    = 1'b0;
		do_merge  = 1'b0;
		do_emit   = 1'b0;
		s_tready  = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = s_tuser ? S_RD_CHK : S_SEG_END;
				end
			end
			S_SEG_END: state_d = S_SEG_CHK;
			S_SEG_CHK: begin
				if (!eofin_q && len_q == 16'd0) begin
					state_d = S_DONE;
				end else if (wl_q != 32'd0 && end_q > rp_q
						&& (end_q - rp_q) > {30'b0, wl_q}) begin
					state_d = S_DONE;
				end else if (eofin_q && ((fk_q && fs_q != end_q) || ms_q > end_q)) begin
					state_d = S_DONE;
				end else if (!eofin_q && fk_q && end_q > fs_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SEG_TRIM;
				end
			end
			S_SEG_TRIM: begin
				state_d = (((off_q < rp_q) ? rp_q : off_q) >= end_q) ? S_DONE : S_SW_START;
			end
			S_RD_CHK: begin
				if (fk_q && rp_q >= fs_q) begin
					state_d = S_DONE;
				end else if (count_q == '0) begin
					state_d = S_RD_EOF;
				end else begin
					tbl_ren = 1'b1;
					state_d = S_RD_AVAIL;
				end
			end
			S_RD_AVAIL: state_d = (tbl_rdata.start_off <= rp_q) ? S_RD_TAKE : S_RD_EOF;
			S_RD_TAKE:  state_d = S_RD_UPD;
			S_RD_UPD:   state_d = S_RD_EOF;
			S_RD_EOF:   state_d = hit_q ? S_SW_START : S_DONE;
			S_SW_START: begin
				tbl_ren = 1'b1;
				state_d = (count_q == '0) ? S_SW_TAIL : S_SW_RUN;
			end
			S_SW_RUN: begin
				if (!act_q && pend_q) begin
					if (tbl_rdata.end_off < s_q) begin
						tbl_wen = 1'b1;
						do_adv  = 1'b1;
					end else if (tbl_rdata.start_off <= e_q) begin
						do_merge = 1'b1;
						do_adv   = 1'b1;
					end else if (full_hit) begin
						state_d = S_DONE;
					end else begin
						do_emit   = 1'b1;
						tbl_wen   = 1'b1;
						tbl_wdata = '{start_off: s_q, end_off: e_q, eof: f_q};
					end
				end else if (act_q && k_q == '0) begin
					do_adv    = 1'b1;
					tbl_wen   = !drop_q;
					tbl_wdata = '{start_off: rp_q, end_off: tbl_rdata.end_off,
						eof: tbl_rdata.eof};
				end else begin
					tbl_wen = 1'b1;
					do_adv  = 1'b1;
				end
				if (do_adv) begin
					if (last_k) begin
						state_d = S_SW_TAIL;
					end else begin
						tbl_ren  = 1'b1;
						tbl_ridx = k_nx[IW-1:0];
					end
				end
			end
			S_SW_TAIL: begin
				if (!act_q && pend_q && !full_hit) begin
					tbl_wen   = 1'b1;
					tbl_wdata = '{start_off: s_q, end_off: e_q, eof: f_q};
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= '0; rp_q <= '0; fs_q <= '0; fk_q <= 1'b0; ms_q <= '0;
			count_q <= '0; bank_q <= 1'b0; st_q <= ST_OK;
			pend_q <= 1'b0; merged_q <= 1'b0; hit_q <= 1'b0; drop_q <= 1'b0;
			k_q <= '0; w_q <= '0;
			ooff_q <= '0; olen_q <= '0; oeof_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				wl_q <= cfg_wr_data;
			end
			// output register: set when a result is loaded, cleared on transfer
			if (state_q == S_DONE && out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q   <= s_tuser;
						eofin_q <= s_tlast;
						off_q   <= s_tdata[61:0];
						len_q   <= s_tdata[77:62];
						amt_q   <= s_tdata[109:78];
						st_q    <= ST_OK;
						ooff_q  <= '0;
						olen_q  <= '0;
						oeof_q  <= 1'b0;
						hit_q   <= 1'b0;
					end
				end
				S_SEG_END: end_q <= sum[62] ? {OFF_W{1'b1}} : sum[OFF_W-1:0];
				S_SEG_CHK: begin
					if (!eofin_q && len_q == 16'd0) begin
						st_q <= ST_OK;
					end else if (wl_q != 32'd0 && end_q > rp_q
							&& (end_q - rp_q) > {30'b0, wl_q}) begin
						st_q <= ST_WINDOW;
					end else if (eofin_q && fk_q && fs_q != end_q) begin
						st_q <= ST_BAD_EOF;
					end else if (eofin_q && ms_q > end_q) begin
						st_q <= ST_EOF_MID;
					end else if (!eofin_q && fk_q && end_q > fs_q) begin
						st_q <= ST_AFTER;
					end else begin
						if (eofin_q) begin
							fs_q <= end_q;
							fk_q <= 1'b1;
						end
						if (end_q > ms_q) begin
							ms_q <= end_q;
						end
					end
				end
				S_SEG_TRIM: begin
					s_q      <= (off_q < rp_q) ? rp_q : off_q;
					e_q      <= end_q;
					f_q      <= eofin_q;
					pend_q   <= 1'b1;
					merged_q <= 1'b0;
				end
				S_RD_CHK: begin
					ooff_q <= rp_q;
					if (fk_q && rp_q >= fs_q) begin
						oeof_q <= 1'b1;
					end
				end
				S_RD_AVAIL: begin
					hit_q   <= (tbl_rdata.start_off <= rp_q);
					avail_q <= tbl_rdata.end_off - rp_q;
				end
				S_RD_TAKE: begin
					drop_q <= (amt_q == 32'd0) || ({30'b0, amt_q} >= avail_q);
					take_q <= ((amt_q == 32'd0) || ({30'b0, amt_q} > avail_q))
						? avail_q : {30'b0, amt_q};
				end
				S_RD_UPD: begin
					rp_q   <= rp_q + take_q;
					olen_q <= take_q;
				end
				S_RD_EOF: oeof_q <= fk_q && (rp_q == fs_q);
				S_SW_START: begin
					k_q <= '0;
					w_q <= '0;
				end
				S_SW_RUN: begin
					if (tbl_wen) begin
						w_q <= w_q + CW'(1);
					end
					if (do_adv) begin
						k_q <= k_nx;
					end
					if (do_merge) begin
						merged_q <= 1'b1;
						if (tbl_rdata.start_off < s_q) begin
							s_q <= tbl_rdata.start_off;
						end
						if (tbl_rdata.end_off > e_q) begin
							e_q <= tbl_rdata.end_off;
						end
						f_q <= f_q | tbl_rdata.eof;
					end
					if (do_emit) begin
						pend_q <= 1'b0;
					end
					if (!act_q && pend_q && !do_adv && !do_emit) begin
						st_q <= ST_FULL;
					end
				end
				S_SW_TAIL: begin
					if (!act_q && pend_q && full_hit) begin
						st_q <= ST_FULL;
					end else begin
						count_q <= w_q + CW'(tbl_wen);
						bank_q  <= !bank_q;
					end
				end
				S_DONE: begin
					if (out_load) begin
						m_data_q  <= {6'b0, ms_q, olen_q, ooff_q};
						m_last_q  <= oeof_q;
						m_user_q  <= st_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_user_q;

	`SRRT_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= MAXC)
	`SRRT_ASSERT_IMP(a_wr_in_range, clk, arst_n, tbl_wen, w_q < MAXC)
	`SRRT_ASSERT_IMP(a_rp_le_final, clk, arst_n, fk_q, rp_q <= fs_q)
	`SRRT_ASSERT_NXT(a_accept_busy, clk, arst_n, s_tvalid && s_tready, state_q != S_IDLE)
endmodule
`default_nettype wire
